// File: design/assert_macros.svh
// assertion macros shared by the clock calendar rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ccc_pkg.sv
// types, constants and calendar functions for the clock calendar counter
`default_nettype none

package ccc_pkg;

    localparam int TICK_COUNT_BITS = 32;
    localparam int TICK_OUT_W      = 32;
    localparam int YEAR_W          = 14;
    localparam int SET_W           = 7;
    localparam int OP_W            = 2;
    localparam int CFG_ADDR_W      = 1;
    localparam int S_TDATA_W       = 48;
    localparam int M_TDATA_W       = 72;

    localparam logic [YEAR_W-1:0] YEAR_TOP   = 14'd9999;
    localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd2000;

    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TIME = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_DATE = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_YEAR_LO = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_YEAR_HI = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SET_W-1:0]  set_hour;
        logic [SET_W-1:0]  set_minute;
        logic [SET_W-1:0]  set_day;
        logic [SET_W-1:0]  set_month;
        logic [YEAR_W-1:0] set_year;
    } item_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } time_t;

    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } date_t;

    // divisibility by 25 through a reciprocal multiply, exact below 2^14
    function automatic logic div_by_25(input logic [YEAR_W-1:0] y);
        logic [29:0] prod;
        logic [9:0]  q;
        logic [14:0] q25;
        prod = 30'(y) * 30'd20972;
        q    = prod[28:19];
        q25  = 15'({q, 4'b0000}) + 15'({q, 3'b000}) + 15'(q);
        return q25 == 15'(y);
    endfunction

    // gregorian rule, with 100 = 4 * 25 and 400 = 16 * 25
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (!div_by_25(y) || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] dim;
        case (month)
            4'd2: begin
                dim = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                dim = 5'd30;
            end
            default: begin
                dim = 5'd31;
            end
        endcase
        return dim;
    endfunction

endpackage

`default_nettype wire

// File: design/clock_calendar_counter.sv
// clock calendar counter top level: input stage, time and date units, result stage
//
//  channel   | ports                          | beat contents
//  ----------+--------------------------------+-------------------------------------
//  input     | s_tvalid s_tready s_tdata s_tuser | op in tuser, set values in tdata
//  result    | m_tvalid m_tready m_tdata      | time, date and tick count
//  config    | cfg_we cfg_addr cfg_wdata      | low and high year limits
//
// input register, then result register; one item per cycle unless the result
// stalls: the time and date update is one pass of logic off the input register
// synchronous active-low reset clears the clock to 00:00:00, 1 Jan 2000, ticks 0
// a stalled result holds the result register; the input register takes beats while it
// is empty or the result register is free or being drained
`default_nettype none

module clock_calendar_counter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    // set_hour[6:0] set_minute[13:7] set_day[20:14] set_month[27:21] set_year[41:28]
    input  wire logic [ccc_pkg::S_TDATA_W-1:0]      s_tdata,
    // op[1:0]
    input  wire logic [ccc_pkg::OP_W-1:0]           s_tuser,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // hour[4:0] minute[10:5] second[16:11] day[21:17] month[25:22] year[39:26]
    // tick_count[71:40]
    output      logic [ccc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [ccc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [ccc_pkg::YEAR_W-1:0]         cfg_wdata
);

    logic                                 in_vld_reg;
    ccc_pkg::item_t                       item_reg;
    logic                                 out_vld_reg;
    logic [ccc_pkg::M_TDATA_W-1:0]        out_data_reg;
    logic                                 advance;
    logic                                 fire;
    logic                                 s_accept;
    logic                                 day_adv;
    ccc_pkg::time_t                       time_next;
    ccc_pkg::date_t                       date_next;
    logic [ccc_pkg::TICK_OUT_W-1:0]       tick_next;

    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.op         <= s_tuser;
            item_reg.set_hour   <= s_tdata[6:0];
            item_reg.set_minute <= s_tdata[13:7];
            item_reg.set_day    <= s_tdata[20:14];
            item_reg.set_month  <= s_tdata[27:21];
            item_reg.set_year   <= s_tdata[41:28];
        end
    end

    ccc_time_unit u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item_reg),
        .time_next (time_next),
        .tick_next (tick_next),
        .day_adv   (day_adv)
    );

    ccc_date_unit u_date (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item_reg),
        .day_adv   (day_adv),
        .date_next (date_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {tick_next, date_next.year, date_next.month, date_next.day,
                             time_next.second, time_next.minute, time_next.hour};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: design/ccc_time_unit.sv
// time of day and tick counter registers with their update logic
`default_nettype none

`include "assert_macros.svh"

module ccc_time_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       fire,
    input  wire ccc_pkg::item_t             item,
    output      ccc_pkg::time_t             time_next,
    output      logic [ccc_pkg::TICK_OUT_W-1:0] tick_next,
    output      logic                       day_adv
);

    ccc_pkg::time_t                         time_reg;
    logic [ccc_pkg::TICK_COUNT_BITS-1:0]    tick_reg;
    logic [ccc_pkg::TICK_COUNT_BITS-1:0]    tick_reg_next;
    logic                                   wrap_sec;
    logic                                   wrap_min;
    logic                                   wrap_hour;
    logic                                   is_tick;

    assign is_tick   = (item.op == ccc_pkg::OP_TICK);
    assign wrap_sec  = (time_reg.second >= 6'd59);
    assign wrap_min  = wrap_sec && (time_reg.minute >= 6'd59);
    assign wrap_hour = wrap_min && (time_reg.hour >= 5'd23);
    assign day_adv   = is_tick && wrap_hour;

    always_comb begin
        time_next     = time_reg;
        tick_reg_next = tick_reg;
        case (item.op)
            ccc_pkg::OP_TICK: begin
                tick_reg_next    = tick_reg + 1'b1;
                time_next.second = wrap_sec ? 6'd0 : time_reg.second + 6'd1;
                if (wrap_sec) begin
                    time_next.minute = wrap_min ? 6'd0 : time_reg.minute + 6'd1;
                end
                if (wrap_min) begin
                    time_next.hour = wrap_hour ? 5'd0 : time_reg.hour + 5'd1;
                end
            end
            ccc_pkg::OP_SET_TIME: begin
                time_next.hour   = (item.set_hour > 7'd23) ? 5'd23 : item.set_hour[4:0];
                time_next.minute = (item.set_minute > 7'd59) ? 6'd59 : item.set_minute[5:0];
                time_next.second = 6'd0;
            end
            default: begin
            end
        endcase
    end

    assign tick_next = ccc_pkg::TICK_OUT_W'(tick_reg_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            tick_reg <= '0;
        end else if (fire) begin
            time_reg <= time_next;
            tick_reg <= tick_reg_next;
        end
    end

    `CCC_ASSERT_NEXT(a_sec_step, aclk, aresetn, fire && is_tick && !wrap_sec, time_reg.second == $past(time_reg.second) + 6'd1, "second did not step on a tick")
    `CCC_ASSERT_NEXT(a_tick_hold, aclk, aresetn, !(fire && is_tick), tick_reg == $past(tick_reg), "tick counter moved without a tick")

endmodule

`default_nettype wire

// File: design/ccc_date_unit.sv
// calendar registers, year limits and the date update logic
`default_nettype none

`include "assert_macros.svh"

module ccc_date_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ccc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ccc_pkg::YEAR_W-1:0]     cfg_wdata,
    input  wire logic                           fire,
    input  wire ccc_pkg::item_t                 item,
    input  wire logic                           day_adv,
    output      ccc_pkg::date_t                 date_next
);

    ccc_pkg::date_t               date_reg;
    logic [ccc_pkg::YEAR_W-1:0]   year_lo_reg;
    logic [ccc_pkg::YEAR_W-1:0]   year_hi_reg;
    logic [4:0]                   dim_cur;
    logic [ccc_pkg::YEAR_W-1:0]   lo_year;
    logic [ccc_pkg::YEAR_W-1:0]   hi_year;
    logic [ccc_pkg::YEAR_W-1:0]   set_year_c;
    logic [3:0]                   set_month_c;
    logic [4:0]                   dim_set;
    logic [4:0]                   set_day_c;
    logic                         day_ok;
    logic                         month_ok;

    assign dim_cur = ccc_pkg::days_in(date_reg.month, ccc_pkg::is_leap(date_reg.year));

    // clamp order: year, then month, then day against the clamped month and year
    always_comb begin
        lo_year = (year_lo_reg > ccc_pkg::YEAR_TOP) ? ccc_pkg::YEAR_TOP : year_lo_reg;
        hi_year = (year_hi_reg > ccc_pkg::YEAR_TOP) ? ccc_pkg::YEAR_TOP : year_hi_reg;
        set_year_c = item.set_year;
        if (item.set_year < lo_year) begin
            set_year_c = lo_year;
        end
        if (item.set_year > hi_year) begin
            set_year_c = hi_year;
        end
        if (item.set_month == 7'd0) begin
            set_month_c = 4'd1;
        end else if (item.set_month > 7'd12) begin
            set_month_c = 4'd12;
        end else begin
            set_month_c = item.set_month[3:0];
        end
        dim_set = ccc_pkg::days_in(set_month_c, ccc_pkg::is_leap(set_year_c));
        if (item.set_day == 7'd0) begin
            set_day_c = 5'd1;
        end else if (item.set_day > 7'(dim_set)) begin
            set_day_c = dim_set;
        end else begin
            set_day_c = item.set_day[4:0];
        end
    end

    always_comb begin
        date_next = date_reg;
        case (item.op)
            ccc_pkg::OP_SET_DATE: begin
                date_next.year  = set_year_c;
                date_next.month = set_month_c;
                date_next.day   = set_day_c;
            end
            default: begin
                if (day_adv) begin
                    if (date_reg.day < dim_cur) begin
                        date_next.day = date_reg.day + 5'd1;
                    end else begin
                        date_next.day = 5'd1;
                        if (date_reg.month < 4'd12) begin
                            date_next.month = date_reg.month + 4'd1;
                        end else begin
                            date_next.month = 4'd1;
                            date_next.year  = (date_reg.year >= ccc_pkg::YEAR_TOP) ?
                                              '0 : date_reg.year + 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            date_reg.day   <= 5'd1;
            date_reg.month <= 4'd1;
            date_reg.year  <= ccc_pkg::RESET_YEAR;
        end else if (fire) begin
            date_reg <= date_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_lo_reg <= '0;
            year_hi_reg <= ccc_pkg::YEAR_TOP;
        end else if (cfg_we) begin
            case (cfg_addr)
                ccc_pkg::CFG_YEAR_LO: begin
                    year_lo_reg <= cfg_wdata;
                end
                ccc_pkg::CFG_YEAR_HI: begin
                    year_hi_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign day_ok   = (date_reg.day >= 5'd1) && (date_reg.day <= dim_cur);
    assign month_ok = (date_reg.month >= 4'd1) && (date_reg.month <= 4'd12);

    `CCC_ASSERT(a_day_range, aclk, aresetn, day_ok, "day outside its month")
    `CCC_ASSERT(a_month_range, aclk, aresetn, month_ok, "month out of range")

endmodule

`default_nettype wire
